FILE: hw/rtl/fmqd_pkg.sv
// Shared constants, types and the CORDIC arctangent table of the FM demodulator.
package fmqd_pkg;

    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 20;

    localparam int PHASE_BITS     = 32;
    localparam int ANGLE_BITS     = 16;
    localparam int GAIN_BITS      = 16;
    localparam int ALPHA_BITS     = 16;
    localparam int AUDIO_BITS     = 16;
    localparam int ACC_BITS       = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_SCALE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_COEF   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEEMPH_ENABLE = 2'd2;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

    typedef logic [PHASE_BITS-1:0] phase_t;

    localparam phase_t PHASE_PI    = 32'h8000_0000;
    localparam phase_t ANGLE_ROUND = 32'h0000_8000;

    // Pipeline control that travels alongside each word.
    typedef struct packed {
        logic valid;
        logic eob;
        logic zero;
    } ctl_t;

    // Configuration register file as seen by the back end.
    typedef struct packed {
        logic [GAIN_BITS-1:0]  gain_scale;
        logic [ALPHA_BITS-1:0] smooth_coef;
        logic                  deemph_enable;
    } cfg_t;

    // atan(2^-k) with 2^32 standing for a full turn.
    function automatic phase_t atan_entry(input int k);
        phase_t v;
        case (k)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/fmqd_front.sv
// Conjugate product of the current and previous sample and the pi pre-rotation.
module fmqd_front #(
    parameter int SAMPLE_BITS = fmqd_pkg::SAMPLE_BITS_DEF,
    parameter int CW          = 2 * fmqd_pkg::SAMPLE_BITS_DEF + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_q,
    input  logic                          eob,
    output logic signed [CW-1:0]          x,
    output logic signed [CW-1:0]          y,
    output fmqd_pkg::phase_t              z,
    output fmqd_pkg::ctl_t                ctl
);
    import fmqd_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] last_i_reg;
    logic signed [SAMPLE_BITS-1:0] last_q_reg;
    logic signed [PW-1:0]          p_ii_reg;
    logic signed [PW-1:0]          p_qq_reg;
    logic signed [PW-1:0]          p_qi_reg;
    logic signed [PW-1:0]          p_iq_reg;
    logic                          p_valid_reg;
    logic                          p_eob_reg;

    logic signed [CW-1:0] di;
    logic signed [CW-1:0] dq;
    logic                 neg;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    phase_t               z_reg;
    ctl_t                 ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_i_reg  <= '0;
            last_q_reg  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            p_valid_reg <= 1'b0;
            p_eob_reg   <= 1'b0;
            ctl_reg     <= '0;
        end
        else if (adv)
        begin
            p_valid_reg   <= in_valid;
            p_eob_reg     <= eob;
            ctl_reg.valid <= p_valid_reg;
            ctl_reg.eob   <= p_eob_reg;
            ctl_reg.zero  <= (di == '0) && (dq == '0);
            if (in_valid)
            begin
                last_i_reg <= sample_i;
                last_q_reg <= sample_q;
            end
        end
    end

    assign di  = CW'(p_ii_reg) + CW'(p_qq_reg);
    assign dq  = CW'(p_qi_reg) - CW'(p_iq_reg);
    assign neg = di[CW-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ii_reg <= sample_i * last_i_reg;
            p_qq_reg <= sample_q * last_q_reg;
            p_qi_reg <= sample_q * last_i_reg;
            p_iq_reg <= sample_i * last_q_reg;
            // A vector in the left half plane is turned by pi first.
            x_reg    <= neg ? -di : di;
            y_reg    <= neg ? -dq : dq;
            z_reg    <= neg ? PHASE_PI : '0;
        end
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign z   = z_reg;
    assign ctl = ctl_reg;

endmodule

FILE: hw/rtl/fmqd_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
module fmqd_cordic_cell #(
    parameter int CW    = 2 * fmqd_pkg::SAMPLE_BITS_DEF + 3,
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  fmqd_pkg::phase_t     z_in,
    input  fmqd_pkg::ctl_t       ctl_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output fmqd_pkg::phase_t     z_out,
    output fmqd_pkg::ctl_t       ctl_out
);
    import fmqd_pkg::*;

    localparam phase_t ATAN = atan_entry(STAGE);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    phase_t               z_next;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    phase_t               z_reg;
    ctl_t                 ctl_reg;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!y_in[CW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign ctl_out = ctl_reg;

endmodule

FILE: hw/rtl/fmqd_back.sv
// Angle rounding, gain with saturation, de-emphasis low-pass and the output register.
module fmqd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  fmqd_pkg::phase_t                    z,
    input  fmqd_pkg::ctl_t                      ctl,
    input  fmqd_pkg::cfg_t                      cfg,
    output logic signed [fmqd_pkg::AUDIO_BITS-1:0] audio,
    output logic                                out_valid,
    output logic                                out_eob
);
    import fmqd_pkg::*;

    phase_t                       z_rnd;
    logic signed [ANGLE_BITS-1:0] angle;

    logic signed [32:0]           prod_reg;
    logic                         g1_valid_reg;
    logic                         g1_eob_reg;

    logic signed [33:0]           scaled;
    logic signed [AUDIO_BITS-1:0] byp_sat;
    logic signed [AUDIO_BITS-1:0] byp_reg;
    logic                         g2_valid_reg;
    logic                         g2_eob_reg;

    logic signed [ACC_BITS:0]     diff;
    logic signed [41:0]           wdiff;
    logic signed [41:0]           step;
    logic signed [42:0]           acc_sum;
    logic signed [ACC_BITS-1:0]   acc_next;
    logic signed [ACC_BITS:0]     acc_rnd;
    logic signed [ACC_BITS:0]     acc_sh;
    logic signed [AUDIO_BITS-1:0] lp_audio;

    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [AUDIO_BITS-1:0] audio_reg;
    logic                         out_valid_reg;
    logic                         out_eob_reg;

    always_comb
    begin
        z_rnd = z + ANGLE_ROUND;
        angle = ctl.zero ? '0 : $signed(z_rnd[PHASE_BITS-1 -: ANGLE_BITS]);
    end

    always_comb
    begin
        scaled = (34'(prod_reg) + 34'sd2048) >>> 12;
        if (scaled > 34'sd32767)
        begin
            byp_sat = 16'sh7FFF;
        end
        else if (scaled < -34'sd32768)
        begin
            byp_sat = 16'sh8000;
        end
        else
        begin
            byp_sat = scaled[AUDIO_BITS-1:0];
        end
    end

    always_comb
    begin
        diff    = 25'($signed({byp_reg, 8'h00})) - 25'(acc_reg);
        wdiff   = $signed({1'b0, cfg.smooth_coef}) * diff;
        step    = (wdiff + 42'sd32768) >>> 16;
        acc_sum = 43'(acc_reg) + 43'(step);
        if (acc_sum > 43'sd8388607)
        begin
            acc_next = 24'sh7FFFFF;
        end
        else if (acc_sum < -43'sd8388608)
        begin
            acc_next = 24'sh800000;
        end
        else
        begin
            acc_next = acc_sum[ACC_BITS-1:0];
        end
        acc_rnd = 25'(acc_next) + 25'sd128;
        acc_sh  = acc_rnd >>> 8;
        if (acc_sh > 25'sd32767)
        begin
            lp_audio = 16'sh7FFF;
        end
        else if (acc_sh < -25'sd32768)
        begin
            lp_audio = 16'sh8000;
        end
        else
        begin
            lp_audio = acc_sh[AUDIO_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg  <= 1'b0;
            g1_eob_reg    <= 1'b0;
            g2_valid_reg  <= 1'b0;
            g2_eob_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_eob_reg   <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            g1_valid_reg  <= ctl.valid;
            g1_eob_reg    <= ctl.eob;
            g2_valid_reg  <= g1_valid_reg;
            g2_eob_reg    <= g1_eob_reg;
            out_valid_reg <= g2_valid_reg;
            out_eob_reg   <= g2_eob_reg;
            // The accumulator only moves for real words while the filter is on.
            if (g2_valid_reg && cfg.deemph_enable)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= angle * $signed({1'b0, cfg.gain_scale});
            byp_reg   <= byp_sat;
            audio_reg <= cfg.deemph_enable ? lp_audio : byp_reg;
        end
    end

    assign audio     = audio_reg;
    assign out_valid = out_valid_reg;
    assign out_eob   = out_eob_reg;

endmodule

FILE: hw/rtl/fm_quadrature_demodulator_top.sv
// Top level of the FM quadrature discriminator with de-emphasis.
//
// Each word on the slave stream carries one complex baseband sample: tdata
// holds I in the low SAMPLE_BITS bits and Q in the next SAMPLE_BITS bits,
// and tlast marks the end of a software block. Each accepted word yields
// exactly one word on the master stream: a Q1.15 audio sample in tdata with
// the block marker copied to tlast.
// The sample is multiplied by the conjugate of the previous sample, its
// angle is found by a row of CORDIC cells (one micro-rotation per cell),
// scaled by gain_scale and optionally smoothed by a one-pole low-pass.
// Throughput is one word per cycle while the receiver keeps taking results;
// an accepted word passes the front-end, CORDIC cell and back-end registers.
// The rate is set by the de-emphasis accumulator loop in the back end.
// When the receiver holds m_tready low with a word waiting, the whole pipeline
// freezes and s_tready drops in the same cycle, so nothing is lost. Reset
// empties the pipeline, sets the previous sample to (0, full scale), clears
// the low-pass state and loads the register defaults. Configuration is to be
// written through cfg_we/cfg_index/cfg_data while idle; the block does not check.
module fm_quadrature_demodulator_top #(
    parameter int SAMPLE_BITS   = fmqd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = fmqd_pkg::CORDIC_STAGES_DEF,
    localparam int IN_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Slave stream. tdata: sample_i, sample_q, zero padding.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [IN_DATA_BITS-1:0]               s_tdata,
    input  logic                                  s_tlast,
    // Master stream. tdata: audio.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fmqd_pkg::AUDIO_BITS-1:0]       m_tdata,
    output logic                                  m_tlast,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [fmqd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fmqd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import fmqd_pkg::*;

    // Room for the conjugate product plus CORDIC gain growth.
    localparam int CW = 2 * SAMPLE_BITS + 3;

    cfg_t cfg_reg;
    logic adv;
    logic in_valid;
    logic out_valid;

    logic signed [CW-1:0] x_chain [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_chain [0:CORDIC_STAGES];
    phase_t               z_chain [0:CORDIC_STAGES];
    ctl_t                 c_chain [0:CORDIC_STAGES];

    logic signed [AUDIO_BITS-1:0] audio;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;
    assign in_valid = s_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_scale    <= GAIN_RESET;
            cfg_reg.smooth_coef   <= '0;
            cfg_reg.deemph_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_SCALE:    cfg_reg.gain_scale    <= cfg_data[GAIN_BITS-1:0];
                REG_SMOOTH_COEF:   cfg_reg.smooth_coef   <= cfg_data[ALPHA_BITS-1:0];
                REG_DEEMPH_ENABLE: cfg_reg.deemph_enable <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    fmqd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CW          (CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .sample_i ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .sample_q ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .eob      (s_tlast),
        .x        (x_chain[0]),
        .y        (y_chain[0]),
        .z        (z_chain[0]),
        .ctl      (c_chain[0])
    );

    // One cell per micro-rotation; each hands its vector to the next.
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        fmqd_cordic_cell #(
            .CW    (CW),
            .STAGE (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .x_in    (x_chain[k]),
            .y_in    (y_chain[k]),
            .z_in    (z_chain[k]),
            .ctl_in  (c_chain[k]),
            .x_out   (x_chain[k+1]),
            .y_out   (y_chain[k+1]),
            .z_out   (z_chain[k+1]),
            .ctl_out (c_chain[k+1])
        );
    end

    fmqd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .z         (z_chain[CORDIC_STAGES]),
        .ctl       (c_chain[CORDIC_STAGES]),
        .cfg       (cfg_reg),
        .audio     (audio),
        .out_valid (out_valid),
        .out_eob   (m_tlast)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = audio;

endmodule

FILE: hw/rtl/fmqd_checker.sv
// Port-level checks of the FM demodulator and their binding to the top level.
module fmqd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fmqd_pkg::AUDIO_BITS-1:0]   m_tdata
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A stall at the output reaches the input in the same cycle.
    a_stall_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during an output stall");

endmodule

bind fm_quadrature_demodulator_top fmqd_checker u_fmqd_checker (.*);
